/* rtl/vrmc_pkg.sv */
// Shared types, widths and codes for the velocity ramp mode controller.
package vrmc_pkg;

    localparam int SPEED_W  = 20;
    localparam int MAXSPD_W = 19;
    localparam int STEP_W   = 16;
    localparam int PERIOD_W = 10;
    localparam int KIND_W   = 3;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAXSPD_W;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ESTOP = 3'd4;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOPPING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ESTOP    = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd3;

    // Register reset values
    localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST     = 19'd10000;
    localparam logic [STEP_W-1:0]   ACCEL_STEP_RST    = 16'd100;
    localparam logic [STEP_W-1:0]   STOP_STEP_RST     = 16'd200;
    localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = 10'd10;

    typedef struct packed {
        logic [MAXSPD_W-1:0] max_speed;
        logic [STEP_W-1:0]   accel_step;
        logic [STEP_W-1:0]   stop_step;
        logic [PERIOD_W-1:0] update_period;
    } t_cfg;

    typedef struct packed {
        logic signed [SPEED_W-1:0] current_speed;
        logic signed [SPEED_W-1:0] target_speed;
        logic [MODE_W-1:0]         mode;
        logic                      emergency_active;
    } t_status;

endpackage

/* rtl/vrmc_cfg.sv */
// Configuration register file of the velocity ramp mode controller.
module vrmc_cfg import vrmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Load the addressed register on a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed     <= MAX_SPEED_RST;
            r_cfg.accel_step    <= ACCEL_STEP_RST;
            r_cfg.stop_step     <= STOP_STEP_RST;
            r_cfg.update_period <= UPDATE_PERIOD_RST;
        end else if (i_wr) begin
            unique case (i_index)
                REG_MAX_SPEED:     r_cfg.max_speed     <= i_data;
                REG_ACCEL_STEP:    r_cfg.accel_step    <= i_data[STEP_W-1:0];
                REG_STOP_STEP:     r_cfg.stop_step     <= i_data[STEP_W-1:0];
                REG_UPDATE_PERIOD: r_cfg.update_period <= i_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/vrmc_core.sv */
// Mode and speed state with the next-state logic for one item.
module vrmc_core import vrmc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic signed [SPEED_W-1:0] i_req,
    input  t_cfg                      i_cfg,
    output t_status                   o_next
);

    logic signed [SPEED_W-1:0] r_speed, n_speed;
    logic signed [SPEED_W-1:0] r_goal, n_goal;
    logic [MODE_W-1:0]         r_mode, n_mode;
    logic [PERIOD_W-1:0]       r_elapsed, n_elapsed;

    logic [PERIOD_W:0]         cnt;
    logic [SPEED_W-1:0]        mag_raw;
    logic [SPEED_W-1:0]        mag;
    logic signed [SPEED_W-1:0] ramp_speed;
    logic signed [SPEED_W-1:0] stop_speed;

    // Move cur toward goal by step, landing exactly on goal
    function automatic logic signed [SPEED_W-1:0] ramp_to(
        input logic signed [SPEED_W-1:0] cur,
        input logic signed [SPEED_W-1:0] goal,
        input logic [STEP_W-1:0]         step
    );
        logic signed [SPEED_W:0] cur_x;
        logic signed [SPEED_W:0] goal_x;
        logic signed [SPEED_W:0] step_x;
        logic signed [SPEED_W:0] up;
        logic signed [SPEED_W:0] dn;
        logic signed [SPEED_W-1:0] res;
        cur_x  = {cur[SPEED_W-1], cur};
        goal_x = {goal[SPEED_W-1], goal};
        step_x = signed'({{(SPEED_W+1-STEP_W){1'b0}}, step});
        up     = cur_x + step_x;
        dn     = cur_x - step_x;
        res    = goal;
        if (cur < goal) begin
            if (up <= goal_x) begin
                res = up[SPEED_W-1:0];
            end
        end else if (cur > goal) begin
            if (dn >= goal_x) begin
                res = dn[SPEED_W-1:0];
            end
        end
        return res;
    endfunction

    // Clamped request magnitude and the two ramp candidates
    always_comb begin
        mag_raw = i_req[SPEED_W-1] ? (~i_req + 1'b1) : i_req;
        mag     = (mag_raw > {1'b0, i_cfg.max_speed}) ? {1'b0, i_cfg.max_speed} : mag_raw;
        cnt     = {1'b0, r_elapsed} + 1'b1;
        ramp_speed = ramp_to(r_speed, r_goal, i_cfg.accel_step);
        stop_speed = ramp_to(r_speed, '0, i_cfg.stop_step);
    end

    // Next state for the item at hand
    always_comb begin
        n_speed   = r_speed;
        n_goal    = r_goal;
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        unique case (i_kind)
            KIND_TICK: begin
                if (cnt >= {1'b0, i_cfg.update_period}) begin
                    n_elapsed = '0;
                    case (r_mode)
                        MODE_UP, MODE_DOWN: n_speed = ramp_speed;
                        MODE_STOPPING: begin
                            n_speed = stop_speed;
                            if (stop_speed == '0) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                        MODE_ESTOP: ;
                        default: n_speed = '0;
                    endcase
                end else begin
                    n_elapsed = cnt[PERIOD_W-1:0];
                end
            end
            KIND_UP: begin
                n_goal = signed'(mag);
                n_mode = (mag == '0) ? MODE_IDLE : MODE_UP;
            end
            KIND_DOWN: begin
                n_goal = -signed'(mag);
                n_mode = (mag == '0) ? MODE_IDLE : MODE_DOWN;
            end
            KIND_STOP: begin
                n_goal = '0;
                n_mode = (r_speed == '0) ? MODE_IDLE : MODE_STOPPING;
            end
            KIND_ESTOP: begin
                n_goal  = '0;
                n_speed = '0;
                n_mode  = MODE_ESTOP;
            end
            default: ;
        endcase
    end

    // Commit state when the item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_goal    <= '0;
            r_mode    <= MODE_IDLE;
            r_elapsed <= '0;
        end else if (i_fire) begin
            r_speed   <= n_speed;
            r_goal    <= n_goal;
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_next.current_speed    = n_speed;
    assign o_next.target_speed     = n_goal;
    assign o_next.mode             = n_mode;
    assign o_next.emergency_active = (n_mode == MODE_ESTOP);

endmodule

/* rtl/velocity_ramp_mode_controller.sv */
// Path: the input register holds the accepted item, then the result register holds its result.
// Throughput: one item per cycle while i_stall is low; a new item is taken while a result
// waits in the output register. The rate is set by the single next-state pass of the ramp
// and mode logic.
// Reset (synchronous, active low): speed, target and tick count zero, mode idle,
// registers at their defaults, both pipeline registers empty.
module velocity_ramp_mode_controller import vrmc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic signed [SPEED_W-1:0] i_speed_request,
    // result output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [SPEED_W-1:0] o_current_speed,
    output logic signed [SPEED_W-1:0] o_target_speed,
    output logic [MODE_W-1:0]         o_mode,
    output logic                      o_emergency_active,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    logic                      r_in_valid;
    logic [KIND_W-1:0]         r_kind;
    logic signed [SPEED_W-1:0] r_req;
    logic                      r_out_valid;
    t_status                   r_out;

    logic    advance;
    logic    in_xfer;
    t_cfg    cfg;
    t_status next_status;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    vrmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Advance the held item when the result register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= i_kind;
            r_req  <= i_speed_request;
        end
    end

    vrmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_kind  (r_kind),
        .i_req   (r_req),
        .i_cfg   (cfg),
        .o_next  (next_status)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_status;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_current_speed    = r_out.current_speed;
    assign o_target_speed     = r_out.target_speed;
    assign o_mode             = r_out.mode;
    assign o_emergency_active = r_out.emergency_active;

endmodule
